### rtl/core/acmc_pkg.sv
// Shared types and constants for the alarm clock menu controller.
`timescale 1ns / 1ps
`default_nettype none

package acmc_pkg;

  typedef enum logic [1:0] {
    CMD_SECOND = 2'd0,
    CMD_PWM    = 2'd1,
    CMD_LOOP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    MENU_NORMAL      = 4'd0,
    MENU_CLK_HOURS   = 4'd1,
    MENU_CLK_MINUTES = 4'd2,
    MENU_CLK_SECONDS = 4'd3,
    MENU_ASK_ALARM   = 4'd4,
    MENU_WAKE_HOURS  = 4'd5,
    MENU_WAKE_MINS   = 4'd6,
    MENU_WAKE_SECS   = 4'd7,
    MENU_ASK_TEMP    = 4'd8,
    MENU_TEMP_LEVEL  = 4'd9,
    MENU_ASK_LIGHT   = 4'd10,
    MENU_LIGHT_LEVEL = 4'd11,
    MENU_ENABLE      = 4'd12
  } menu_e;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_TIME  = 2'd1,
    CAUSE_TEMP  = 2'd2,
    CAUSE_LIGHT = 2'd3
  } cause_e;

  typedef enum logic [2:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_TEMP_LOW      = 3'd1,
    REG_TEMP_HIGH     = 3'd2,
    REG_LIGHT_LOW     = 3'd3,
    REG_LIGHT_HIGH    = 3'd4
  } reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [4:0] HoursMax   = 5'd23;
  localparam logic [5:0] MinSecMax  = 6'd59;
  localparam logic [9:0] DutyStep   = 10'd20;
  localparam logic [9:0] DutyPeriod = 10'd500;

  localparam logic [7:0] SamplePeriodRst = 8'd1;
  localparam logic [7:0] TempLowRst      = 8'd0;
  localparam logic [7:0] TempHighRst     = 8'd50;
  localparam logic [7:0] LightLowRst     = 8'd0;
  localparam logic [7:0] LightHighRst    = 8'd7;

endpackage

`default_nettype wire

### rtl/core/alarm_clock_menu_controller_core.sv
// Top level of the alarm clock menu controller: clock, sensor alarms and settings menu.
//
// An event request enters on the in_ channel (command, button levels, sensor
// samples) and is taken at a clock edge with in_valid_i high and in_stall_o low.
// Each event produces exactly one result request on the out_ channel carrying
// the full state after that event. The request is held in an input register,
// then its state update is computed and loaded into the state registers, which
// double as the result register.
// Throughput is one event per cycle while out_stall_i is low; the only
// recurrence is the update of the state registers.
// When the receiver raises out_stall_i the result stays on the outputs, the
// pending input register holds its request and in_stall_o rises once that
// register is full. Configuration writes through cfg_we_i take effect at once
// and are meant for when no request is in flight.
// Reset clears the clock, alarm time, thresholds, menu and LED duty to zero,
// sets the sample period to one second and restores the default limits.
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_menu_controller_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [acmc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [acmc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [1:0]                command_i,
  input  wire logic                      button_one_i,
  input  wire logic                      button_two_i,
  input  wire logic [7:0]                temperature_i,
  input  wire logic [7:0]                light_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [3:0]                     menu_state_o,
  output logic [1:0]                     alarm_cause_o,
  output logic [4:0]                     clock_hours_o,
  output logic [5:0]                     clock_minutes_o,
  output logic [5:0]                     clock_seconds_o,
  output logic                           alarm_enabled_o,
  output logic [4:0]                     alarm_hours_o,
  output logic [5:0]                     alarm_minutes_o,
  output logic [5:0]                     alarm_seconds_o,
  output logic [7:0]                     temp_threshold_o,
  output logic [7:0]                     light_threshold_o,
  output logic [8:0]                     led_duty_o
);
  import acmc_pkg::*;

  logic [7:0] sample_period_q, temp_low_q, temp_high_q, light_low_q, light_high_q;

  logic       s1_valid_q;
  cmd_e       cmd_q;
  logic       b1_q, b2_q;
  logic [7:0] temp_q, light_q;

  logic       out_valid_q;
  logic       out_ready;
  logic       s1_fire;
  logic       in_fire;

  menu_e      menu_q, menu_d;
  cause_e     cause_q, cause_d, cause_chk;
  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic [7:0] phase_q, phase_d;
  logic       enable_q, enable_d;
  logic [4:0] wake_hours_q, wake_hours_d;
  logic [5:0] wake_minutes_q, wake_minutes_d;
  logic [5:0] wake_seconds_q, wake_seconds_d;
  logic [7:0] temp_level_q, temp_level_d;
  logic [7:0] light_level_q, light_level_d;
  logic [8:0] duty_q, duty_d;

  logic       sampling;
  logic [8:0] phase_inc;
  logic [9:0] duty_sum;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= SamplePeriodRst;
      temp_low_q      <= TempLowRst;
      temp_high_q     <= TempHighRst;
      light_low_q     <= LightLowRst;
      light_high_q    <= LightHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i;
        REG_TEMP_LOW:      temp_low_q      <= cfg_data_i;
        REG_TEMP_HIGH:     temp_high_q     <= cfg_data_i;
        REG_LIGHT_LOW:     light_low_q     <= cfg_data_i;
        REG_LIGHT_HIGH:    light_high_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_e'(command_i);
      b1_q    <= button_one_i;
      b2_q    <= button_two_i;
      temp_q  <= temperature_i;
      light_q <= light_i;
    end
  end

  // Sensor check runs before the menu step on a loop pass.
  assign sampling = (sample_period_q != 8'd0) && (phase_q == 8'd0) && enable_q &&
                    (cause_q == CAUSE_NONE);

  always_comb begin
    cause_chk = cause_q;
    if (cmd_q == CMD_LOOP && sampling) begin
      priority if (temp_q > temp_level_q) begin
        cause_chk = CAUSE_TEMP;
      end else if (light_q < light_level_q) begin
        cause_chk = CAUSE_LIGHT;
      end else if (hours_q == wake_hours_q && minutes_q == wake_minutes_q &&
                   seconds_q == wake_seconds_q) begin
        cause_chk = CAUSE_TIME;
      end
    end
  end

  // Next menu position.
  always_comb begin
    menu_d = menu_q;
    if (cmd_q == CMD_LOOP) begin
      unique case (menu_q)
        MENU_NORMAL:      if (b1_q && cause_chk == CAUSE_NONE) menu_d = MENU_CLK_HOURS;
        MENU_CLK_HOURS:   if (!b2_q && b1_q) menu_d = MENU_CLK_MINUTES;
        MENU_CLK_MINUTES: if (!b2_q && b1_q) menu_d = MENU_CLK_SECONDS;
        MENU_CLK_SECONDS: if (!b2_q && b1_q) menu_d = MENU_ASK_ALARM;
        MENU_ASK_ALARM: begin
          if (b2_q) menu_d = MENU_WAKE_HOURS;
          else if (b1_q) menu_d = MENU_ASK_TEMP;
        end
        MENU_WAKE_HOURS:  if (!b2_q && b1_q) menu_d = MENU_WAKE_MINS;
        MENU_WAKE_MINS:   if (!b2_q && b1_q) menu_d = MENU_WAKE_SECS;
        MENU_WAKE_SECS:   if (!b2_q && b1_q) menu_d = MENU_ASK_TEMP;
        MENU_ASK_TEMP: begin
          if (b2_q) menu_d = MENU_TEMP_LEVEL;
          else if (b1_q) menu_d = MENU_ASK_LIGHT;
        end
        MENU_TEMP_LEVEL:  if (!b2_q && b1_q) menu_d = MENU_ASK_LIGHT;
        MENU_ASK_LIGHT: begin
          if (b2_q) menu_d = MENU_LIGHT_LEVEL;
          else if (b1_q) menu_d = MENU_ENABLE;
        end
        MENU_LIGHT_LEVEL: if (!b2_q && b1_q) menu_d = MENU_ENABLE;
        MENU_ENABLE:      if (!b2_q && b1_q) menu_d = MENU_NORMAL;
        default:          menu_d = MENU_NORMAL;
      endcase
    end
  end

  // Datapath updates driven by the command and the menu position.
  always_comb begin
    cause_d        = cause_q;
    hours_d        = hours_q;
    minutes_d      = minutes_q;
    seconds_d      = seconds_q;
    phase_d        = phase_q;
    enable_d       = enable_q;
    wake_hours_d   = wake_hours_q;
    wake_minutes_d = wake_minutes_q;
    wake_seconds_d = wake_seconds_q;
    temp_level_d   = temp_level_q;
    light_level_d  = light_level_q;
    duty_d         = duty_q;
    phase_inc      = {1'b0, phase_q} + 9'd1;
    duty_sum       = {1'b0, duty_q} + DutyStep;

    unique case (cmd_q)
      CMD_SECOND: begin
        if (seconds_q >= MinSecMax) begin
          seconds_d = 6'd0;
          if (minutes_q >= MinSecMax) begin
            minutes_d = 6'd0;
            hours_d   = (hours_q >= HoursMax) ? 5'd0 : hours_q + 5'd1;
          end else begin
            minutes_d = minutes_q + 6'd1;
          end
        end else begin
          seconds_d = seconds_q + 6'd1;
        end
        if (sample_period_q == 8'd0 || phase_inc >= {1'b0, sample_period_q}) begin
          phase_d = 8'd0;
        end else begin
          phase_d = phase_inc[7:0];
        end
      end
      CMD_PWM: begin
        if (cause_q != CAUSE_NONE) begin
          duty_d = (duty_sum >= DutyPeriod) ? 9'(duty_sum - DutyPeriod) : duty_sum[8:0];
        end
      end
      CMD_LOOP: begin
        cause_d = cause_chk;
        // In normal mode the mode button clears a latched alarm whatever the change button does.
        if (b1_q && menu_q == MENU_NORMAL && cause_chk != CAUSE_NONE) begin
          cause_d = CAUSE_NONE;
        end
        if (b2_q) begin
          unique case (menu_q)
            MENU_CLK_HOURS:
              hours_d = (hours_q >= HoursMax) ? 5'd0 : hours_q + 5'd1;
            MENU_CLK_MINUTES:
              minutes_d = (minutes_q >= MinSecMax) ? 6'd0 : minutes_q + 6'd1;
            MENU_CLK_SECONDS:
              seconds_d = (seconds_q >= MinSecMax) ? 6'd0 : seconds_q + 6'd1;
            MENU_WAKE_HOURS:
              wake_hours_d = (wake_hours_q >= HoursMax) ? 5'd0 : wake_hours_q + 5'd1;
            MENU_WAKE_MINS:
              wake_minutes_d = (wake_minutes_q >= MinSecMax) ? 6'd0 : wake_minutes_q + 6'd1;
            MENU_WAKE_SECS:
              wake_seconds_d = (wake_seconds_q >= MinSecMax) ? 6'd0 : wake_seconds_q + 6'd1;
            MENU_TEMP_LEVEL:
              temp_level_d = (temp_level_q == temp_high_q) ? temp_low_q : temp_level_q + 8'd1;
            MENU_LIGHT_LEVEL:
              light_level_d = (light_level_q == light_high_q) ? light_low_q
                                                              : light_level_q + 8'd1;
            MENU_ENABLE:
              enable_d = !enable_q;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      menu_q         <= MENU_NORMAL;
      cause_q        <= CAUSE_NONE;
      hours_q        <= 5'd0;
      minutes_q      <= 6'd0;
      seconds_q      <= 6'd0;
      phase_q        <= 8'd0;
      enable_q       <= 1'b0;
      wake_hours_q   <= 5'd0;
      wake_minutes_q <= 6'd0;
      wake_seconds_q <= 6'd0;
      temp_level_q   <= TempLowRst;
      light_level_q  <= LightLowRst;
      duty_q         <= 9'd0;
    end else begin
      if (s1_fire) begin
        out_valid_q    <= 1'b1;
        menu_q         <= menu_d;
        cause_q        <= cause_d;
        hours_q        <= hours_d;
        minutes_q      <= minutes_d;
        seconds_q      <= seconds_d;
        phase_q        <= phase_d;
        enable_q       <= enable_d;
        wake_hours_q   <= wake_hours_d;
        wake_minutes_q <= wake_minutes_d;
        wake_seconds_q <= wake_seconds_d;
        temp_level_q   <= temp_level_d;
        light_level_q  <= light_level_d;
        duty_q         <= duty_d;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign menu_state_o      = menu_q;
  assign alarm_cause_o     = cause_q;
  assign clock_hours_o     = hours_q;
  assign clock_minutes_o   = minutes_q;
  assign clock_seconds_o   = seconds_q;
  assign alarm_enabled_o   = enable_q;
  assign alarm_hours_o     = wake_hours_q;
  assign alarm_minutes_o   = wake_minutes_q;
  assign alarm_seconds_o   = wake_seconds_q;
  assign temp_threshold_o  = temp_level_q;
  assign light_threshold_o = light_level_q;
  assign led_duty_o        = duty_q;

  a_clock_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hours_q <= HoursMax && minutes_q <= MinSecMax && seconds_q <= MinSecMax)
    else $error("clock counter out of range");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, duty_q} < DutyPeriod)
    else $error("LED duty out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(hours_q) && $stable(minutes_q) && $stable(seconds_q) &&
                 $stable(cause_q) && $stable(duty_q))
    else $error("state changed without a request");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free pipeline");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("request lost between stages");

endmodule

`default_nettype wire

### tb/sv/alarm_clock_menu_controller_checker.sv
// Checker that tracks the alarm clock state per request and compares every result field.
`timescale 1ns / 1ps

module alarm_clock_menu_controller_checker
  import acmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          command_i,
  input  logic                button_one_i,
  input  logic                button_two_i,
  input  logic [7:0]          temperature_i,
  input  logic [7:0]          light_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [3:0]          menu_state_i,
  input  logic [1:0]          alarm_cause_i,
  input  logic [4:0]          clock_hours_i,
  input  logic [5:0]          clock_minutes_i,
  input  logic [5:0]          clock_seconds_i,
  input  logic                alarm_enabled_i,
  input  logic [4:0]          alarm_hours_i,
  input  logic [5:0]          alarm_minutes_i,
  input  logic [5:0]          alarm_seconds_i,
  input  logic [7:0]          temp_threshold_i,
  input  logic [7:0]          light_threshold_i,
  input  logic [8:0]          led_duty_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_count_o
);

  typedef struct packed {
    logic [3:0] menu;
    logic [1:0] cause;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       enabled;
    logic [4:0] wake_hours;
    logic [5:0] wake_minutes;
    logic [5:0] wake_seconds;
    logic [7:0] temp_level;
    logic [7:0] light_level;
    logic [8:0] duty;
  } clock_status_t;

  clock_status_t expected_status[$];
  int unsigned   mismatches = 0;

  logic [7:0] period_q, temp_low_q, temp_high_q, light_low_q, light_high_q;
  menu_e      menu_q;
  cause_e     cause_q;
  logic [4:0] hours_q, wake_hours_q;
  logic [5:0] minutes_q, seconds_q, wake_minutes_q, wake_seconds_q;
  logic [7:0] phase_q, temp_level_q, light_level_q;
  logic       enable_q;
  logic [8:0] duty_q;

  function automatic int unsigned step_wrap(input int unsigned v, input int unsigned top);
    return (v >= top) ? 0 : v + 1;
  endfunction

  function automatic logic [7:0] step_level(input logic [7:0] v, input logic [7:0] hi,
                                            input logic [7:0] lo);
    return (v == hi) ? lo : v + 8'd1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    clock_status_t want;
    logic [9:0]    duty_sum;
    logic [8:0]    phase_next;
    logic          b1;
    logic          b2;
    if (!rst_ni) begin
      period_q       = SamplePeriodRst;
      temp_low_q     = TempLowRst;
      temp_high_q    = TempHighRst;
      light_low_q    = LightLowRst;
      light_high_q   = LightHighRst;
      menu_q         = MENU_NORMAL;
      cause_q        = CAUSE_NONE;
      hours_q        = '0;
      minutes_q      = '0;
      seconds_q      = '0;
      phase_q        = '0;
      enable_q       = 1'b0;
      wake_hours_q   = '0;
      wake_minutes_q = '0;
      wake_seconds_q = '0;
      temp_level_q   = TempLowRst;
      light_level_q  = LightLowRst;
      duty_q         = '0;
      expected_status.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_SAMPLE_PERIOD: period_q = cfg_data_i;
          REG_TEMP_LOW:      temp_low_q = cfg_data_i;
          REG_TEMP_HIGH:     temp_high_q = cfg_data_i;
          REG_LIGHT_LOW:     light_low_q = cfg_data_i;
          REG_LIGHT_HIGH:    light_high_q = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("menu_state", want.menu, menu_state_i);
          check_field("alarm_cause", want.cause, alarm_cause_i);
          check_field("clock_hours", want.hours, clock_hours_i);
          check_field("clock_minutes", want.minutes, clock_minutes_i);
          check_field("clock_seconds", want.seconds, clock_seconds_i);
          check_field("alarm_enabled", want.enabled, alarm_enabled_i);
          check_field("alarm_hours", want.wake_hours, alarm_hours_i);
          check_field("alarm_minutes", want.wake_minutes, alarm_minutes_i);
          check_field("alarm_seconds", want.wake_seconds, alarm_seconds_i);
          check_field("temp_threshold", want.temp_level, temp_threshold_i);
          check_field("light_threshold", want.light_level, light_threshold_i);
          check_field("led_duty", want.duty, led_duty_i);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        b1 = button_one_i;
        b2 = button_two_i;
        case (cmd_e'(command_i))
          CMD_SECOND: begin
            if (seconds_q == MinSecMax) begin
              seconds_q = '0;
              if (minutes_q == MinSecMax) begin
                minutes_q = '0;
                hours_q = (hours_q == HoursMax) ? '0 : hours_q + 5'd1;
              end else begin
                minutes_q = minutes_q + 6'd1;
              end
            end else begin
              seconds_q = seconds_q + 6'd1;
            end
            if (period_q == '0) begin
              phase_q = '0;
            end else begin
              phase_next = {1'b0, phase_q} + 9'd1;
              phase_q = (phase_next >= {1'b0, period_q}) ? '0 : phase_next[7:0];
            end
          end
          CMD_PWM: begin
            if (cause_q != CAUSE_NONE) begin
              duty_sum = {1'b0, duty_q} + DutyStep;
              duty_q = (duty_sum >= DutyPeriod) ? 9'(duty_sum - DutyPeriod) : duty_sum[8:0];
            end
          end
          CMD_LOOP: begin
            if (period_q != '0 && phase_q == '0 && enable_q && cause_q == CAUSE_NONE) begin
              if (temperature_i > temp_level_q) begin
                cause_q = CAUSE_TEMP;
              end else if (light_i < light_level_q) begin
                cause_q = CAUSE_LIGHT;
              end else if (hours_q == wake_hours_q && minutes_q == wake_minutes_q &&
                           seconds_q == wake_seconds_q) begin
                cause_q = CAUSE_TIME;
              end
            end
            case (menu_q)
              MENU_NORMAL: begin
                if (b1) begin
                  if (cause_q == CAUSE_NONE) menu_q = MENU_CLK_HOURS;
                  else cause_q = CAUSE_NONE;
                end
              end
              MENU_CLK_HOURS: begin
                if (b2) hours_q = 5'(step_wrap(hours_q, HoursMax));
                else if (b1) menu_q = MENU_CLK_MINUTES;
              end
              MENU_CLK_MINUTES: begin
                if (b2) minutes_q = 6'(step_wrap(minutes_q, MinSecMax));
                else if (b1) menu_q = MENU_CLK_SECONDS;
              end
              MENU_CLK_SECONDS: begin
                if (b2) seconds_q = 6'(step_wrap(seconds_q, MinSecMax));
                else if (b1) menu_q = MENU_ASK_ALARM;
              end
              MENU_ASK_ALARM: begin
                if (b2) menu_q = MENU_WAKE_HOURS;
                else if (b1) menu_q = MENU_ASK_TEMP;
              end
              MENU_WAKE_HOURS: begin
                if (b2) wake_hours_q = 5'(step_wrap(wake_hours_q, HoursMax));
                else if (b1) menu_q = MENU_WAKE_MINS;
              end
              MENU_WAKE_MINS: begin
                if (b2) wake_minutes_q = 6'(step_wrap(wake_minutes_q, MinSecMax));
                else if (b1) menu_q = MENU_WAKE_SECS;
              end
              MENU_WAKE_SECS: begin
                if (b2) wake_seconds_q = 6'(step_wrap(wake_seconds_q, MinSecMax));
                else if (b1) menu_q = MENU_ASK_TEMP;
              end
              MENU_ASK_TEMP: begin
                if (b2) menu_q = MENU_TEMP_LEVEL;
                else if (b1) menu_q = MENU_ASK_LIGHT;
              end
              MENU_TEMP_LEVEL: begin
                if (b2) temp_level_q = step_level(temp_level_q, temp_high_q, temp_low_q);
                else if (b1) menu_q = MENU_ASK_LIGHT;
              end
              MENU_ASK_LIGHT: begin
                if (b2) menu_q = MENU_LIGHT_LEVEL;
                else if (b1) menu_q = MENU_ENABLE;
              end
              MENU_LIGHT_LEVEL: begin
                if (b2) light_level_q = step_level(light_level_q, light_high_q, light_low_q);
                else if (b1) menu_q = MENU_ENABLE;
              end
              MENU_ENABLE: begin
                if (b2) enable_q = ~enable_q;
                else if (b1) menu_q = MENU_NORMAL;
              end
              default: menu_q = MENU_NORMAL;
            endcase
          end
          default: ;
        endcase
        expected_status.push_back('{menu_q, cause_q, hours_q, minutes_q, seconds_q, enable_q,
                                    wake_hours_q, wake_minutes_q, wake_seconds_q,
                                    temp_level_q, light_level_q, duty_q});
      end
    end
    pending_count_o <= expected_status.size();
    fail_count_o    <= mismatches;
  end

endmodule

### tb/sv/alarm_clock_menu_controller_core_test.sv
// Top of the alarm clock menu controller test: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module alarm_clock_menu_controller_core_test;
  import acmc_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          command_i = '0;
  logic                button_one_i = 1'b0;
  logic                button_two_i = 1'b0;
  logic [7:0]          temperature_i = '0;
  logic [7:0]          light_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [3:0]          menu_state_o;
  logic [1:0]          alarm_cause_o;
  logic [4:0]          clock_hours_o;
  logic [5:0]          clock_minutes_o;
  logic [5:0]          clock_seconds_o;
  logic                alarm_enabled_o;
  logic [4:0]          alarm_hours_o;
  logic [5:0]          alarm_minutes_o;
  logic [5:0]          alarm_seconds_o;
  logic [7:0]          temp_threshold_o;
  logic [7:0]          light_threshold_o;
  logic [8:0]          led_duty_o;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  logic        stall_enable = 1'b0;
  logic        gap_enable = 1'b0;

  alarm_clock_menu_controller_core DUT (.*);

  alarm_clock_menu_controller_checker state_check (
    .*,
    .in_stall_i        (in_stall_o),
    .out_valid_i       (out_valid_o),
    .menu_state_i      (menu_state_o),
    .alarm_cause_i     (alarm_cause_o),
    .clock_hours_i     (clock_hours_o),
    .clock_minutes_i   (clock_minutes_o),
    .clock_seconds_i   (clock_seconds_o),
    .alarm_enabled_i   (alarm_enabled_o),
    .alarm_hours_i     (alarm_hours_o),
    .alarm_minutes_i   (alarm_minutes_o),
    .alarm_seconds_i   (alarm_seconds_o),
    .temp_threshold_i  (temp_threshold_o),
    .light_threshold_i (light_threshold_o),
    .led_duty_i        (led_duty_o),
    .fail_count_o      (fail_count),
    .pending_count_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!stall_enable) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = $urandom_range(0, 9);
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("alarm_clock_menu_controller_core_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sensor values cluster at both ends so that every alarm comparison can go either way.
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 3));
      1:       return 8'($urandom_range(0, 255));
      default: return 8'hFF;
    endcase
  endfunction

  task automatic send_event(input cmd_e cmd, input logic b1, input logic b2,
                            input logic [7:0] temp, input logic [7:0] lum);
    if (gap_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    button_one_i  <= b1;
    button_two_i  <= b2;
    temperature_i <= temp;
    light_i       <= lum;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [7:0] period, input logic [7:0] temp_lo,
                               input logic [7:0] temp_hi, input logic [7:0] light_lo,
                               input logic [7:0] light_hi);
    drain(4);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_TEMP_LOW, temp_lo);
    write_reg(REG_TEMP_HIGH, temp_hi);
    write_reg(REG_LIGHT_LOW, light_lo);
    write_reg(REG_LIGHT_HIGH, light_hi);
    cfg_we_i <= 1'b0;
  endtask

  // Button levels are held over runs of events so that edits reach their wraps.
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned hold_left;
    int unsigned pick;
    logic        b1;
    logic        b2;
    cmd_e        cmd;
    sent = 0;
    hold_left = 0;
    b1 = 1'b0;
    b2 = 1'b0;
    while (sent < count) begin
      if (hold_left == 0) begin
        hold_left = $urandom_range(1, 30);
        pick = $urandom_range(0, 99);
        b1 = (pick < 35) || (pick >= 90);
        b2 = (pick >= 35 && pick < 65) || (pick >= 90);
      end
      hold_left--;
      pick = $urandom_range(0, 99);
      if (pick < 62) cmd = CMD_LOOP;
      else if (pick < 82) cmd = CMD_SECOND;
      else if (pick < 97) cmd = CMD_PWM;
      else cmd = CMD_NONE;
      send_event(cmd, b1, b2, pick_sample(), pick_sample());
      if (cmd != CMD_NONE) sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    gap_enable = 1'b1;
    stall_enable <= 1'b1;

    send_event(CMD_NONE, 1'b1, 1'b1, 8'hFF, 8'hFF);
    send_event(CMD_LOOP, 1'b0, 1'b1, 8'h00, 8'h00);
    send_event(CMD_LOOP, 1'b1, 1'b0, pick_sample(), pick_sample());
    send_event(CMD_LOOP, 1'b1, 1'b1, pick_sample(), pick_sample());
    repeat (3) send_event(CMD_LOOP, 1'b1, 1'b0, pick_sample(), pick_sample());
    repeat (2) send_event(CMD_LOOP, 1'b0, 1'b1, pick_sample(), pick_sample());
    repeat (3) send_event(CMD_LOOP, 1'b1, 1'b0, pick_sample(), pick_sample());
    repeat (2) send_event(CMD_LOOP, 1'b0, 1'b1, pick_sample(), pick_sample());
    send_event(CMD_LOOP, 1'b1, 1'b0, pick_sample(), pick_sample());
    repeat (2) send_event(CMD_LOOP, 1'b0, 1'b1, pick_sample(), pick_sample());
    send_event(CMD_LOOP, 1'b1, 1'b0, pick_sample(), pick_sample());
    send_event(CMD_LOOP, 1'b0, 1'b1, pick_sample(), pick_sample());
    // The clock and the wake time both read one o'clock here, so leaving the menu latches.
    send_event(CMD_LOOP, 1'b1, 1'b0, 8'h00, 8'hFF);
    send_event(CMD_PWM, 1'b0, 1'b0, 8'h00, 8'h00);
    send_event(CMD_LOOP, 1'b1, 1'b0, 8'h00, 8'hFF);
    send_event(CMD_LOOP, 1'b0, 1'b0, 8'hFF, 8'hFF);
    send_event(CMD_LOOP, 1'b1, 1'b0, 8'h00, 8'hFF);
    send_event(CMD_LOOP, 1'b0, 1'b0, 8'h00, 8'h00);
    send_event(CMD_SECOND, 1'b1, 1'b1, 8'h00, 8'h00);
    send_event(CMD_LOOP, 1'b1, 1'b0, 8'h00, 8'hFF);
    run_random(62);

    load_settings(8'd0, 8'd0, 8'd255, 8'd0, 8'd255);
    run_random(80);

    load_settings(8'd255, 8'd255, 8'd0, 8'd255, 8'd0);
    run_random(80);

    load_settings(8'd2, 8'd10, 8'd12, 8'd3, 8'd5);
    stall_enable <= 1'b0;
    run_random(80);

    load_settings(SamplePeriodRst, TempLowRst, TempHighRst, LightLowRst, LightHighRst);
    gap_enable = 1'b0;
    run_random(90);

    drain(8);
    if (fail_count == 0 && pending_count == 0) begin
      $display("alarm_clock_menu_controller_core_test OK");
    end else begin
      $display("alarm_clock_menu_controller_core_test NOT OK");
    end
    $finish;
  end

endmodule
